// ===== hdl/rmq_pkg.sv =====
// Package with widths, slot codes and entry types for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int EL_W      = 16;
  localparam int TR_W      = EL_W + 2;
  localparam int ARG_W     = ((FRAC_BITS > EL_W) ? FRAC_BITS : EL_W) + 3;
  localparam int V_W       = ARG_W - 1 + FRAC_BITS;
  localparam int SQ_STEPS  = (V_W + 1) / 2;
  localparam int RW        = 2 * SQ_STEPS;
  localparam int S_W       = SQ_STEPS;
  localparam int D_W       = EL_W + 1;
  localparam int MAG_W     = D_W;
  localparam int Q_W       = EL_W;
  localparam int N_W       = ((MAG_W + FRAC_BITS > S_W) ? MAG_W + FRAC_BITS : S_W) + 1;
  localparam int DIV_W     = ((N_W > S_W + 1 + Q_W) ? N_W : S_W + 1 + Q_W) + 1;
  localparam int EL_MAX    = (1 << (EL_W - 1)) - 1;
  localparam int LANES     = 3;

  // Which output component takes the half root.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  typedef struct packed {
    logic [1:0]                   hsel;
    logic                         bad;
    logic signed [LANES-1:0][D_W-1:0] d;
    logic [RW-1:0]                v;
    logic [RW-1:0]                r;
  } sq_t;

  typedef struct packed {
    logic [1:0]                   hsel;
    logic                         bad;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0]             ovf;
    logic [LANES-1:0][DIV_W-1:0]  rem;
    logic [LANES-1:0][Q_W-1:0]    q;
    logic [DIV_W-1:0]             dsor;
    logic signed [EL_W-1:0]       half;
  } dv_t;

endpackage

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Pipelined conversion of a Q2.14 rotation matrix into a unit quaternion.
`timescale 1ns / 1ps

// Usage: present the nine matrix elements on m00..m22 with start high. busy
// is always low, so an item is taken on every cycle that start is high.
// Each item comes out on qx, qy, qz, qw and bad_matrix after stage A, the
// root setup and root stages, the division setup, overflow check and quotient
// stages and the output register, with done high for one cycle. Items leave in the order they came in.
// Throughput is one item per cycle: the root is taken one result bit per
// stage over SQ_STEPS stages, and the three quotients run in parallel lanes
// of restoring division, one quotient bit per stage over Q_W stages plus an
// overflow check stage. Quotients that would not fit saturate.
// bad_matrix marks a non-positive root argument; the components are then
// zero. Reset is synchronous and clears every valid bit in the pipeline, so
// items in flight at reset are dropped. The receiver has no way to stall the
// block: results must be taken in the cycle that done is high.
module rotation_matrix_to_quaternion (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rmq_pkg::EL_W-1:0]   m00,
  input  logic signed [rmq_pkg::EL_W-1:0]   m01,
  input  logic signed [rmq_pkg::EL_W-1:0]   m02,
  input  logic signed [rmq_pkg::EL_W-1:0]   m10,
  input  logic signed [rmq_pkg::EL_W-1:0]   m11,
  input  logic signed [rmq_pkg::EL_W-1:0]   m12,
  input  logic signed [rmq_pkg::EL_W-1:0]   m20,
  input  logic signed [rmq_pkg::EL_W-1:0]   m21,
  input  logic signed [rmq_pkg::EL_W-1:0]   m22,
  output logic                              done,
  output logic signed [rmq_pkg::EL_W-1:0]   qx,
  output logic signed [rmq_pkg::EL_W-1:0]   qy,
  output logic signed [rmq_pkg::EL_W-1:0]   qz,
  output logic signed [rmq_pkg::EL_W-1:0]   qw,
  output logic                              bad_matrix
);
  import rmq_pkg::*;

  localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

  function automatic logic signed [EL_W-1:0] sat_q(input logic neg, input logic ovf,
                                                   input logic [Q_W-1:0] q);
    logic big;
    big = ovf | q[Q_W-1];
    if (neg) begin
      sat_q = big ? {1'b1, {(EL_W-1){1'b0}}} : -$signed(EL_W'(q));
    end else begin
      sat_q = big ? {1'b0, {(EL_W-1){1'b1}}} : $signed(EL_W'(q));
    end
  endfunction

  // Stage A: matrix, trace and the largest diagonal entry.
  logic                          a_vld;
  logic signed [EL_W-1:0]        a_m [0:8];
  logic signed [TR_W-1:0]        a_trace;
  logic [1:0]                    a_sel;

  sq_t                 sq      [0:SQ_STEPS];
  sq_t                 sq_next [0:SQ_STEPS];
  logic [SQ_STEPS:0]   sq_vld;
  dv_t                 dv      [0:Q_W+1];
  dv_t                 dv_next [0:Q_W+1];
  logic [Q_W+1:0]      dv_vld;

  logic signed [TR_W-1:0] trace_in;
  logic [1:0]             sel_in;

  assign busy = 1'b0;

  always_comb begin
    trace_in = TR_W'(m00) + TR_W'(m11) + TR_W'(m22);
    if (m00 < m11) begin
      sel_in = (m11 < m22) ? SEL_Z : SEL_Y;
    end else begin
      sel_in = (m00 < m22) ? SEL_Z : SEL_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_m[0]  <= m00;
    a_m[1]  <= m01;
    a_m[2]  <= m02;
    a_m[3]  <= m10;
    a_m[4]  <= m11;
    a_m[5]  <= m12;
    a_m[6]  <= m20;
    a_m[7]  <= m21;
    a_m[8]  <= m22;
    a_trace <= trace_in;
    a_sel   <= sel_in;
  end

  // Root argument, lane operands, then one root bit per stage.
  always_comb begin
    logic signed [ARG_W-1:0] arg;
    logic                    tpos;
    logic [RW:0]             bitv;
    logic [RW:0]             tmp;
    tpos = (a_trace > 0);
    sq_next[0] = '0;
    arg = '0;
    if (tpos) begin
      sq_next[0].hsel = SEL_W;
      arg = ARG_W'(a_trace) + ONE;
      sq_next[0].d[0] = D_W'(a_m[7]) - D_W'(a_m[5]);
      sq_next[0].d[1] = D_W'(a_m[2]) - D_W'(a_m[6]);
      sq_next[0].d[2] = D_W'(a_m[3]) - D_W'(a_m[1]);
    end else begin
      unique case (a_sel)
        SEL_X: begin
          sq_next[0].hsel = SEL_X;
          arg = ARG_W'(a_m[0]) - ARG_W'(a_m[4]) - ARG_W'(a_m[8]) + ONE;
          sq_next[0].d[0] = D_W'(a_m[1]) + D_W'(a_m[3]);
          sq_next[0].d[1] = D_W'(a_m[2]) + D_W'(a_m[6]);
          sq_next[0].d[2] = D_W'(a_m[7]) - D_W'(a_m[5]);
        end
        SEL_Y: begin
          sq_next[0].hsel = SEL_Y;
          arg = ARG_W'(a_m[4]) - ARG_W'(a_m[8]) - ARG_W'(a_m[0]) + ONE;
          sq_next[0].d[0] = D_W'(a_m[3]) + D_W'(a_m[1]);
          sq_next[0].d[1] = D_W'(a_m[5]) + D_W'(a_m[7]);
          sq_next[0].d[2] = D_W'(a_m[2]) - D_W'(a_m[6]);
        end
        default: begin
          sq_next[0].hsel = SEL_Z;
          arg = ARG_W'(a_m[8]) - ARG_W'(a_m[0]) - ARG_W'(a_m[4]) + ONE;
          sq_next[0].d[0] = D_W'(a_m[6]) + D_W'(a_m[2]);
          sq_next[0].d[1] = D_W'(a_m[7]) + D_W'(a_m[5]);
          sq_next[0].d[2] = D_W'(a_m[3]) - D_W'(a_m[1]);
        end
      endcase
    end
    sq_next[0].bad = !tpos && (arg <= 0);
    sq_next[0].v = sq_next[0].bad ? '0 : RW'({arg[ARG_W-2:0], {FRAC_BITS{1'b0}}});
    sq_next[0].r = '0;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_next[k+1] = sq[k];
      bitv = (RW+1)'(1) << (RW - 2 - 2 * k);
      tmp  = {1'b0, sq[k].r} + bitv;
      if ({1'b0, sq[k].v} >= tmp) begin
        sq_next[k+1].v = sq[k].v - tmp[RW-1:0];
        sq_next[k+1].r = (sq[k].r >> 1) + bitv[RW-1:0];
      end else begin
        sq_next[k+1].r = sq[k].r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else begin
      sq_vld <= {sq_vld[SQ_STEPS-1:0], a_vld};
    end
    for (int k = 0; k <= SQ_STEPS; k++) begin
      sq[k] <= sq_next[k];
    end
  end

  // Division lanes: setup, overflow check, then one quotient bit per stage.
  always_comb begin
    logic [S_W-1:0]   s;
    logic [S_W-1:0]   half_u;
    logic [MAG_W-1:0] mag;
    int               b;
    s = sq[SQ_STEPS].r[S_W-1:0];
    half_u = S_W'(({1'b0, s} + (S_W+1)'(1)) >> 1);
    dv_next[0] = '0;
    dv_next[0].hsel = sq[SQ_STEPS].hsel;
    dv_next[0].bad  = sq[SQ_STEPS].bad;
    dv_next[0].dsor = DIV_W'(s) << 1;
    if (32'(half_u) > 32'(EL_MAX)) begin
      dv_next[0].half = EL_W'(EL_MAX);
    end else begin
      dv_next[0].half = EL_W'(half_u);
    end
    for (int l = 0; l < LANES; l++) begin
      dv_next[0].neg[l] = sq[SQ_STEPS].d[l][D_W-1];
      mag = sq[SQ_STEPS].d[l][D_W-1] ? MAG_W'(-sq[SQ_STEPS].d[l]) : MAG_W'(sq[SQ_STEPS].d[l]);
      dv_next[0].rem[l] = (DIV_W'(mag) << FRAC_BITS) + DIV_W'(s);
    end
    dv_next[1] = dv[0];
    for (int l = 0; l < LANES; l++) begin
      dv_next[1].ovf[l] = (dv[0].rem[l] >= (dv[0].dsor << Q_W));
    end
    for (int n = 0; n < Q_W; n++) begin
      b = Q_W - 1 - n;
      dv_next[n+2] = dv[n+1];
      for (int l = 0; l < LANES; l++) begin
        if (!dv[n+1].ovf[l] && (dv[n+1].rem[l] >= (dv[n+1].dsor << b))) begin
          dv_next[n+2].rem[l] = dv[n+1].rem[l] - (dv[n+1].dsor << b);
          dv_next[n+2].q[l][b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else begin
      dv_vld <= {dv_vld[Q_W:0], sq_vld[SQ_STEPS]};
    end
    for (int n = 0; n <= Q_W + 1; n++) begin
      dv[n] <= dv_next[n];
    end
  end

  // Saturate the lanes and place them around the half-root component.
  logic signed [EL_W-1:0] ln0, ln1, ln2, hf;
  logic signed [EL_W-1:0] x_next, y_next, z_next, w_next;

  always_comb begin
    ln0 = sat_q(dv[Q_W+1].neg[0], dv[Q_W+1].ovf[0], dv[Q_W+1].q[0]);
    ln1 = sat_q(dv[Q_W+1].neg[1], dv[Q_W+1].ovf[1], dv[Q_W+1].q[1]);
    ln2 = sat_q(dv[Q_W+1].neg[2], dv[Q_W+1].ovf[2], dv[Q_W+1].q[2]);
    hf  = dv[Q_W+1].half;
    unique case (dv[Q_W+1].hsel)
      SEL_X: begin
        x_next = hf;  y_next = ln0; z_next = ln1; w_next = ln2;
      end
      SEL_Y: begin
        x_next = ln0; y_next = hf;  z_next = ln1; w_next = ln2;
      end
      SEL_Z: begin
        x_next = ln0; y_next = ln1; z_next = hf;  w_next = ln2;
      end
      SEL_W: begin
        x_next = ln0; y_next = ln1; z_next = ln2; w_next = hf;
      end
    endcase
    if (dv[Q_W+1].bad) begin
      x_next = '0;
      y_next = '0;
      z_next = '0;
      w_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[Q_W+1];
    end
    qx         <= x_next;
    qy         <= y_next;
    qz         <= z_next;
    qw         <= w_next;
    bad_matrix <= dv[Q_W+1].bad;
  end

endmodule
